### rtl/core/vision_pan_tilt_tracker_assert.svh
// ----------------------------------------------------------------------------
// Pan/tilt tracker assertion macros
// Clocked assertion shorthands used by the tracker's checker.
// ----------------------------------------------------------------------------
`ifndef VISION_PAN_TILT_TRACKER_ASSERT_SVH
`define VISION_PAN_TILT_TRACKER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define VPT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define VPT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/vpt_pkg.sv
// ----------------------------------------------------------------------------
// Pan/tilt tracker package
// Shared types, codes and constants of the vision pan/tilt tracker.
// ----------------------------------------------------------------------------
package vpt_pkg;

   // Default number of fraction bits of a servo position.
   localparam int FRACTION_BITS = 8;
   // Bits of the whole percent part of a position (0..100).
   localparam int PCT_INT_W = 7;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_FIELDS_W = 34;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   // Operating modes.
   localparam logic [2:0] MODE_IDLE      = 3'd0;
   localparam logic [2:0] MODE_CURIOUS   = 3'd1;
   localparam logic [2:0] MODE_TRACKING  = 3'd2;
   localparam logic [2:0] MODE_FOLLOWING = 3'd3;
   localparam logic [2:0] MODE_SCANNING  = 3'd4;

   // Item kinds.
   localparam logic ACTION_PACKET = 1'b0;
   localparam logic ACTION_TICK   = 1'b1;

   // Object classes.
   localparam logic [1:0] CLASS_NONE   = 2'd0;
   localparam logic [1:0] CLASS_SMALL  = 2'd1;
   localparam logic [1:0] CLASS_MEDIUM = 2'd2;
   localparam logic [1:0] CLASS_LARGE  = 2'd3;

   // Register indexes.
   localparam logic [CSR_ADDR_W-1:0] REG_ENABLED       = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_CENTER_X      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_CENTER_Y      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_SCAN_IDLE_MS  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_LOST_MS       = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_TRACKING_GAIN = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_SMOOTHING     = 3'd6;

   // Register reset values.
   localparam logic        RST_ENABLED       = 1'b0;
   localparam logic [7:0]  RST_CENTER_X      = 8'd80;
   localparam logic [7:0]  RST_CENTER_Y      = 8'd60;
   localparam logic [15:0] RST_SCAN_IDLE_MS  = 16'd8000;
   localparam logic [15:0] RST_LOST_MS       = 16'd500;
   localparam logic [7:0]  RST_TRACKING_GAIN = 8'd13;
   localparam logic [7:0]  RST_SMOOTHING     = 8'd51;

   // Whole-percent positions and limits.
   localparam int PCT_MID      = 50;
   localparam int PCT_MAX      = 100;
   localparam int PAN_LO_PCT   = 10;
   localparam int PAN_HI_PCT   = 90;
   localparam int TILT_LO_PCT  = 20;
   localparam int TILT_HI_PCT  = 80;
   localparam int NECK_LARGE   = 35;
   localparam int NECK_MEDIUM  = 42;
   localparam int SCAN_LOW_PCT = 25;
   localparam int SCAN_HIGH_PCT = 75;

   // Scan pattern timing.
   localparam int SCAN_PERIOD_MS = 4000;
   localparam int SCAN_STEP_MS   = 1000;

   // Servo speeds.
   localparam logic [PCT_INT_W-1:0] SPEED_SCAN  = 7'd30;
   localparam logic [PCT_INT_W-1:0] SPEED_TRACK = 7'd60;

   typedef struct packed {
      logic        enabled;
      logic [7:0]  center_x;
      logic [7:0]  center_y;
      logic [15:0] scan_idle_ms;
      logic [15:0] lost_ms;
      logic [7:0]  tracking_gain;
      logic [7:0]  smoothing;
   } cfg_type;

   typedef struct packed {
      logic        action;
      logic [31:0] time_ms;
      logic        motion;
      logic [1:0]  object_class;
      logic [7:0]  target_x;
      logic [7:0]  target_y;
   } item_type;

   typedef struct packed {
      logic [2:0]           mode;
      logic                 pan_valid;
      logic [PCT_INT_W-1:0] pan_pos;
      logic                 tilt_valid;
      logic [PCT_INT_W-1:0] tilt_pos;
      logic                 neck_valid;
      logic [PCT_INT_W-1:0] neck_pos;
      logic [PCT_INT_W-1:0] move_speed;
   } rsp_type;

endpackage

### rtl/core/vpt_scan_phase.sv
// ----------------------------------------------------------------------------
// Scan phase decoder
// Reduces elapsed scan time modulo the scan period and returns the quarter.
// ----------------------------------------------------------------------------
module vpt_scan_phase (
   input  logic [31:0] elapsed,
   output logic [1:0]  quarter
);

   localparam int P    = vpt_pkg::SCAN_PERIOD_MS;
   localparam int R8   = (1 << 8) % P;
   localparam int R16  = (1 << 16) % P;
   localparam int R24  = (1 << 24) % P;
   localparam int R12  = (1 << 12) % P;

   logic [19:0] fold1;
   logic [14:0] fold2;
   logic [12:0] fold3;
   logic [12:0] phase;

   // Each byte is weighted by its place value reduced modulo the period,
   // then the sum is folded twice at bit 12 and fixed with one subtract.
   always_comb begin
      fold1 = 20'(elapsed[7:0])
            + 20'(elapsed[15:8])  * 20'(R8)
            + 20'(elapsed[23:16]) * 20'(R16)
            + 20'(elapsed[31:24]) * 20'(R24);
      fold2 = 15'(fold1[11:0]) + 15'(fold1[19:12]) * 15'(R12);
      fold3 = 13'(fold2[11:0]) + 13'(fold2[14:12]) * 13'(R12);
      phase = (fold3 >= 13'(P)) ? fold3 - 13'(P) : fold3;
      if (phase < 13'(vpt_pkg::SCAN_STEP_MS)) begin
         quarter = 2'd0;
      end else if (phase < 13'(2 * vpt_pkg::SCAN_STEP_MS)) begin
         quarter = 2'd1;
      end else if (phase < 13'(3 * vpt_pkg::SCAN_STEP_MS)) begin
         quarter = 2'd2;
      end else begin
         quarter = 2'd3;
      end
   end

endmodule

### rtl/core/vpt_goal_step.sv
// ----------------------------------------------------------------------------
// Goal step
// Moves one axis goal by the centre error times the gain, with clamping.
// ----------------------------------------------------------------------------
module vpt_goal_step #(
   parameter int FRACTION_BITS = vpt_pkg::FRACTION_BITS,
   parameter int LO_PCT        = vpt_pkg::PAN_LO_PCT,
   parameter int HI_PCT        = vpt_pkg::PAN_HI_PCT
) (
   input  logic [vpt_pkg::PCT_INT_W+FRACTION_BITS-1:0] goal,
   input  logic [7:0]                                  target,
   input  logic [7:0]                                  center,
   input  logic [7:0]                                  gain,
   output logic [vpt_pkg::PCT_INT_W+FRACTION_BITS-1:0] goal_next
);

   localparam int POS_W = vpt_pkg::PCT_INT_W + FRACTION_BITS;
   // Extended goal: 8 more fraction bits, room for the signed step.
   localparam int EW    = FRACTION_BITS + 19;
   localparam logic signed [EW-1:0] LO_E = EW'(LO_PCT) <<< (FRACTION_BITS + 8);
   localparam logic signed [EW-1:0] HI_E = EW'(HI_PCT) <<< (FRACTION_BITS + 8);

   logic signed [8:0]    err;
   logic signed [17:0]   prod;
   logic signed [EW-1:0] ext;
   logic signed [EW-1:0] clamped;

   always_comb begin
      err  = $signed({1'b0, target}) - $signed({1'b0, center});
      prod = err * $signed({1'b0, gain});
      ext  = $signed({{(EW - POS_W - 8){1'b0}}, goal, 8'b0})
           + (EW'(prod) <<< FRACTION_BITS);
      if (ext < LO_E) begin
         clamped = LO_E;
      end else if (ext > HI_E) begin
         clamped = HI_E;
      end else begin
         clamped = ext;
      end
      goal_next = clamped[POS_W+7:8];
   end

endmodule

### rtl/core/vpt_smooth.sv
// ----------------------------------------------------------------------------
// Servo smoother
// Blends the current servo position toward its goal by the smoothing factor.
// ----------------------------------------------------------------------------
module vpt_smooth #(
   parameter int FRACTION_BITS = vpt_pkg::FRACTION_BITS
) (
   input  logic [vpt_pkg::PCT_INT_W+FRACTION_BITS-1:0] pos,
   input  logic [vpt_pkg::PCT_INT_W+FRACTION_BITS-1:0] goal,
   input  logic [7:0]                                  factor,
   output logic [vpt_pkg::PCT_INT_W+FRACTION_BITS-1:0] pos_next
);

   localparam int POS_W = vpt_pkg::PCT_INT_W + FRACTION_BITS;

   logic [8:0]       keep;
   logic [POS_W+8:0] part_pos;
   logic [POS_W+7:0] part_goal;
   logic [POS_W+9:0] blend;

   always_comb begin
      keep      = 9'd256 - {1'b0, factor};
      part_pos  = pos * keep;
      part_goal = goal * factor;
      blend     = {1'b0, part_pos} + {2'b0, part_goal};
      pos_next  = blend[POS_W+7:8];
   end

endmodule

### rtl/core/vpt_engine.sv
// ----------------------------------------------------------------------------
// Tracker engine
// Mode machine, goal and position state, and the result of one item.
// ----------------------------------------------------------------------------
module vpt_engine #(
   parameter int FRACTION_BITS = vpt_pkg::FRACTION_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  vpt_pkg::cfg_type  cfg,
   input  vpt_pkg::item_type item,
   output vpt_pkg::rsp_type  result
);

   localparam int POS_W = vpt_pkg::PCT_INT_W + FRACTION_BITS;
   localparam logic [POS_W-1:0] POS_MID  = POS_W'(vpt_pkg::PCT_MID) << FRACTION_BITS;
   localparam logic [POS_W-1:0] POS_LOW  = POS_W'(vpt_pkg::SCAN_LOW_PCT) << FRACTION_BITS;
   localparam logic [POS_W-1:0] POS_HIGH = POS_W'(vpt_pkg::SCAN_HIGH_PCT) << FRACTION_BITS;
   localparam logic [POS_W-1:0] POS_NECK_L = POS_W'(vpt_pkg::NECK_LARGE) << FRACTION_BITS;
   localparam logic [POS_W-1:0] POS_NECK_M = POS_W'(vpt_pkg::NECK_MEDIUM) << FRACTION_BITS;
   localparam int PW = vpt_pkg::PCT_INT_W;

   logic [2:0]       mode_ff, mode_in;
   logic [31:0]      entered_ff, entered_in;
   logic [31:0]      seen_ff, seen_in;
   logic [POS_W-1:0] pan_goal_ff, pan_goal_in;
   logic [POS_W-1:0] tilt_goal_ff, tilt_goal_in;
   logic [POS_W-1:0] neck_goal_ff, neck_goal_in;
   logic [POS_W-1:0] pan_now_ff, pan_now_in;
   logic [POS_W-1:0] tilt_now_ff, tilt_now_in;
   logic [POS_W-1:0] neck_now_ff, neck_now_in;

   logic [POS_W-1:0] pan_step, tilt_step;
   logic [POS_W-1:0] pan_smooth, tilt_smooth, neck_smooth;
   logic [31:0]      since;
   logic [31:0]      scan_elapsed;
   logic [1:0]       quarter;
   logic             chasing;
   logic             to_scan;
   logic             in_scan;
   logic [2:0]       pk_mode;
   logic             pk_enter;

   function automatic logic [PW-1:0] whole_pct(input logic [POS_W-1:0] v);
      logic [PW-1:0] w;
      w = v[POS_W-1 -: PW];
      return (w > PW'(vpt_pkg::PCT_MAX)) ? PW'(vpt_pkg::PCT_MAX) : w;
   endfunction

   vpt_goal_step #(
      .FRACTION_BITS (FRACTION_BITS),
      .LO_PCT        (vpt_pkg::PAN_LO_PCT),
      .HI_PCT        (vpt_pkg::PAN_HI_PCT)
   ) u_pan_step (
      .goal      (pan_goal_ff),
      .target    (item.target_x),
      .center    (cfg.center_x),
      .gain      (cfg.tracking_gain),
      .goal_next (pan_step)
   );

   vpt_goal_step #(
      .FRACTION_BITS (FRACTION_BITS),
      .LO_PCT        (vpt_pkg::TILT_LO_PCT),
      .HI_PCT        (vpt_pkg::TILT_HI_PCT)
   ) u_tilt_step (
      .goal      (tilt_goal_ff),
      .target    (item.target_y),
      .center    (cfg.center_y),
      .gain      (cfg.tracking_gain),
      .goal_next (tilt_step)
   );

   vpt_smooth #(.FRACTION_BITS(FRACTION_BITS)) u_pan_smooth (
      .pos (pan_now_ff), .goal (pan_goal_ff), .factor (cfg.smoothing), .pos_next (pan_smooth)
   );

   vpt_smooth #(.FRACTION_BITS(FRACTION_BITS)) u_tilt_smooth (
      .pos (tilt_now_ff), .goal (tilt_goal_ff), .factor (cfg.smoothing), .pos_next (tilt_smooth)
   );

   vpt_smooth #(.FRACTION_BITS(FRACTION_BITS)) u_neck_smooth (
      .pos (neck_now_ff), .goal (neck_goal_ff), .factor (cfg.smoothing), .pos_next (neck_smooth)
   );

   vpt_scan_phase u_scan_phase (
      .elapsed (scan_elapsed),
      .quarter (quarter)
   );

   always_comb begin
      since   = item.time_ms - seen_ff;
      chasing = (mode_ff == vpt_pkg::MODE_TRACKING) || (mode_ff == vpt_pkg::MODE_FOLLOWING);

      // Packet mode step: motion starts tracking (following for a large
      // object); a long quiet spell ends the chase.
      pk_mode  = mode_ff;
      pk_enter = 1'b0;
      if (item.motion) begin
         if ((mode_ff == vpt_pkg::MODE_SCANNING) || (mode_ff == vpt_pkg::MODE_IDLE) ||
             (mode_ff == vpt_pkg::MODE_CURIOUS)) begin
            pk_mode  = vpt_pkg::MODE_TRACKING;
            pk_enter = 1'b1;
         end
         if (item.object_class == vpt_pkg::CLASS_LARGE) begin
            pk_mode  = vpt_pkg::MODE_FOLLOWING;
            pk_enter = 1'b1;
         end
      end else if ((since > {16'b0, cfg.lost_ms}) && chasing) begin
         pk_mode  = vpt_pkg::MODE_IDLE;
         pk_enter = 1'b1;
      end

      to_scan      = (mode_ff == vpt_pkg::MODE_IDLE) && (since > {16'b0, cfg.scan_idle_ms});
      in_scan      = to_scan || (mode_ff == vpt_pkg::MODE_SCANNING);
      scan_elapsed = to_scan ? 32'd0 : item.time_ms - entered_ff;

      mode_in      = mode_ff;
      entered_in   = entered_ff;
      seen_in      = seen_ff;
      pan_goal_in  = pan_goal_ff;
      tilt_goal_in = tilt_goal_ff;
      neck_goal_in = neck_goal_ff;
      pan_now_in   = pan_now_ff;
      tilt_now_in  = tilt_now_ff;
      neck_now_in  = neck_now_ff;
      result       = '0;

      if (item.action == vpt_pkg::ACTION_PACKET) begin
         if (item.motion) begin
            seen_in = item.time_ms;
         end
         if (cfg.enabled) begin
            mode_in = pk_mode;
            if (pk_enter) begin
               entered_in = item.time_ms;
            end
            if ((pk_mode == vpt_pkg::MODE_TRACKING) || (pk_mode == vpt_pkg::MODE_FOLLOWING)) begin
               pan_goal_in  = pan_step;
               tilt_goal_in = tilt_step;
               case (item.object_class)
                  vpt_pkg::CLASS_LARGE:  neck_goal_in = POS_NECK_L;
                  vpt_pkg::CLASS_MEDIUM: neck_goal_in = POS_NECK_M;
                  default:               neck_goal_in = POS_MID;
               endcase
            end
         end
      end else if (cfg.enabled) begin
         if (in_scan) begin
            if (since < {16'b0, cfg.lost_ms}) begin
               mode_in    = vpt_pkg::MODE_IDLE;
               entered_in = item.time_ms;
            end else begin
               mode_in = vpt_pkg::MODE_SCANNING;
               if (to_scan) begin
                  entered_in = item.time_ms;
               end
               pan_goal_in  = POS_MID;
               tilt_goal_in = POS_MID;
               result.pan_pos  = PW'(vpt_pkg::PCT_MID);
               result.tilt_pos = PW'(vpt_pkg::PCT_MID);
               case (quarter)
                  2'd0: begin
                     pan_goal_in    = POS_LOW;
                     result.pan_pos = PW'(vpt_pkg::SCAN_LOW_PCT);
                  end
                  2'd1: begin
                     pan_goal_in    = POS_HIGH;
                     result.pan_pos = PW'(vpt_pkg::SCAN_HIGH_PCT);
                  end
                  2'd2: begin
                     tilt_goal_in    = POS_LOW;
                     result.tilt_pos = PW'(vpt_pkg::SCAN_LOW_PCT);
                  end
                  default: begin
                  end
               endcase
               result.pan_valid  = 1'b1;
               result.tilt_valid = 1'b1;
               result.move_speed = vpt_pkg::SPEED_SCAN;
            end
         end else if (chasing) begin
            pan_now_in  = pan_smooth;
            tilt_now_in = tilt_smooth;
            neck_now_in = neck_smooth;
            result.pan_valid  = 1'b1;
            result.pan_pos    = whole_pct(pan_smooth);
            result.tilt_valid = 1'b1;
            result.tilt_pos   = whole_pct(tilt_smooth);
            result.neck_valid = 1'b1;
            result.neck_pos   = whole_pct(neck_smooth);
            result.move_speed = vpt_pkg::SPEED_TRACK;
         end
      end

      result.mode = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= vpt_pkg::MODE_IDLE;
         entered_ff   <= '0;
         seen_ff      <= '0;
         pan_goal_ff  <= POS_MID;
         tilt_goal_ff <= POS_MID;
         neck_goal_ff <= POS_MID;
         pan_now_ff   <= POS_MID;
         tilt_now_ff  <= POS_MID;
         neck_now_ff  <= POS_MID;
      end else if (step) begin
         mode_ff      <= mode_in;
         entered_ff   <= entered_in;
         seen_ff      <= seen_in;
         pan_goal_ff  <= pan_goal_in;
         tilt_goal_ff <= tilt_goal_in;
         neck_goal_ff <= neck_goal_in;
         pan_now_ff   <= pan_now_in;
         tilt_now_ff  <= tilt_now_in;
         neck_now_ff  <= neck_now_in;
      end
   end

endmodule

### rtl/core/vision_pan_tilt_tracker.sv
// ----------------------------------------------------------------------------
// Vision pan/tilt tracker
// Behavior engine for a pan/tilt/neck head fed by vision packets and ticks.
//
//   Channel  Dir  Handshake              Payload
//   req      in   req_tvalid/req_tready  tuser: action; tdata: item fields
//   rsp      out  rsp_tvalid/rsp_tready  tdata: mode and servo commands
//   csr      in   csr_we                 csr_addr, csr_wdata
//
// One item per cycle is sustained while results are taken; an item is taken into
// the input register, then the engine logic writes its result into the result register.
// The state advances as an item moves from the input register to the result
// register, so each item sees all earlier items.
// Reset is synchronous and restores the config and valid registers, mode and positions at once.
// A stalled result holds the result register, then the input register, and
// only then does req_tready fall.
// ----------------------------------------------------------------------------
module vision_pan_tilt_tracker #(
   parameter int FRACTION_BITS = vpt_pkg::FRACTION_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // time_ms[31:0], motion[32], object_class[34:33], target_x[42:35],
   // target_y[50:43], zero[55:51]
   input  logic [vpt_pkg::REQ_TDATA_W-1:0] req_tdata,
   // action[0]
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // mode[2:0], pan_valid[3], pan_pos[10:4], tilt_valid[11], tilt_pos[18:12],
   // neck_valid[19], neck_pos[26:20], move_speed[33:27], zero[39:34]
   output logic [vpt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             csr_we,
   input  logic [vpt_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [vpt_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   vpt_pkg::cfg_type  cfg_ff, cfg_in;
   vpt_pkg::item_type item_ff, item_in;
   vpt_pkg::rsp_type  rsp_ff, rsp_in;
   logic              in_valid_ff, in_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              advance;

   always_comb begin
      item_in.action       = req_tuser;
      item_in.time_ms      = req_tdata[31:0];
      item_in.motion       = req_tdata[32];
      item_in.object_class = req_tdata[34:33];
      item_in.target_x     = req_tdata[42:35];
      item_in.target_y     = req_tdata[50:43];

      advance      = in_valid_ff && (!rsp_valid_ff || rsp_tready);
      req_tready   = !in_valid_ff || advance;
      in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            vpt_pkg::REG_ENABLED:       cfg_in.enabled       = csr_wdata[0];
            vpt_pkg::REG_CENTER_X:      cfg_in.center_x      = csr_wdata[7:0];
            vpt_pkg::REG_CENTER_Y:      cfg_in.center_y      = csr_wdata[7:0];
            vpt_pkg::REG_SCAN_IDLE_MS:  cfg_in.scan_idle_ms  = csr_wdata;
            vpt_pkg::REG_LOST_MS:       cfg_in.lost_ms       = csr_wdata;
            vpt_pkg::REG_TRACKING_GAIN: cfg_in.tracking_gain = csr_wdata[7:0];
            vpt_pkg::REG_SMOOTHING:     cfg_in.smoothing     = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   vpt_engine #(.FRACTION_BITS(FRACTION_BITS)) u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cfg    (cfg_ff),
      .item   (item_ff),
      .result (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled       <= vpt_pkg::RST_ENABLED;
         cfg_ff.center_x      <= vpt_pkg::RST_CENTER_X;
         cfg_ff.center_y      <= vpt_pkg::RST_CENTER_Y;
         cfg_ff.scan_idle_ms  <= vpt_pkg::RST_SCAN_IDLE_MS;
         cfg_ff.lost_ms       <= vpt_pkg::RST_LOST_MS;
         cfg_ff.tracking_gain <= vpt_pkg::RST_TRACKING_GAIN;
         cfg_ff.smoothing     <= vpt_pkg::RST_SMOOTHING;
         in_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(vpt_pkg::RSP_TDATA_W - vpt_pkg::RSP_FIELDS_W)'(0),
                        rsp_ff.move_speed, rsp_ff.neck_pos, rsp_ff.neck_valid,
                        rsp_ff.tilt_pos, rsp_ff.tilt_valid, rsp_ff.pan_pos,
                        rsp_ff.pan_valid, rsp_ff.mode};

endmodule

### rtl/core/vpt_checker.sv
// ----------------------------------------------------------------------------
// Tracker port checker
// Watches the tracker's ports for result consistency and timing.
// ----------------------------------------------------------------------------
`include "vision_pan_tilt_tracker_assert.svh"

module vpt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [vpt_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic                             req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [vpt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             csr_we,
   input logic [vpt_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input logic [vpt_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic       pan_valid;
   logic       tilt_valid;
   logic       neck_valid;
   logic [2:0] mode;
   logic [6:0] pan_pos;
   logic [6:0] move_speed;

   assign mode       = rsp_tdata[2:0];
   assign pan_valid  = rsp_tdata[3];
   assign pan_pos    = rsp_tdata[10:4];
   assign tilt_valid = rsp_tdata[11];
   assign neck_valid = rsp_tdata[19];
   assign move_speed = rsp_tdata[33:27];

   `VPT_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   `VPT_ASSERT_NOW(a_quiet_result, rsp_tvalid && !pan_valid,
      !tilt_valid && !neck_valid && move_speed == 7'd0 && pan_pos == 7'd0,
      "result without a command carries a position or speed")

   `VPT_ASSERT_NOW(a_scan_command, rsp_tvalid && pan_valid && !neck_valid,
      tilt_valid && move_speed == vpt_pkg::SPEED_SCAN && mode == vpt_pkg::MODE_SCANNING,
      "scan command outside scanning mode")

   `VPT_ASSERT_NEXT(a_latency, (req_tvalid && req_tready) ##1 rsp_tready,
      rsp_tvalid, "accepted item gave no result in time")

endmodule

bind vision_pan_tilt_tracker vpt_checker u_vpt_checker (.*);
